### sv/stt_pkg.sv
// Shared types and constants for the success trace table.
// Used by the front end, request queue, table engine and top level.
`default_nettype none
package stt_pkg;

   localparam logic [1:0] FUNC_RECORD      = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP      = 2'd1;
   localparam logic [1:0] FUNC_CONSOLIDATE = 2'd2;

   localparam logic [0:0] CSR_ENTRY_LIMIT = 1'b0;
   localparam logic [0:0] CSR_MIN_RATE    = 1'b1;

   localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;
   localparam int unsigned STALE_DAYS = 30;
   localparam int unsigned DECAY_DAYS = 14;
   localparam logic [31:0] FAIL_PRUNE = 32'd2;
   localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key_tag;
      logic        succeeded;
      logic [15:0] steps_handle;
      logic [23:0] duration_ms;
      logic [33:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] found_steps;
      logic [31:0] found_avg;
      logic [4:0]  entry_count;
   } rsp_type;

   // Classified command handed from front end to table engine
   typedef struct packed {
      logic        is_record;
      logic        is_lookup;
      logic        is_consol;
      logic [63:0] key;
      logic        succeeded;
      logic [15:0] steps;
      logic [31:0] q_ms;
      logic [33:0] now;
   } cmd_type;

endpackage
`default_nettype wire

### sv/success_trace_table.sv
// Success trace table: a keyed table of task traces, with record, replay lookup
// and consolidate requests. Each request first scans the table one slot per
// cycle; record then applies its update, lookup evaluates the matched slot and
// consolidate evaluates and prunes each slot in turn. The front end and a
// two-entry queue keep taking requests while the engine works, until they fill.
// Depends on stt_pkg, stt_front, stt_queue and stt_engine.
`default_nettype none
module success_trace_table #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 64
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  stt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output stt_pkg::rsp_type rsp_data,
   input  wire              csr_write,
   input  wire [0:0]        csr_index,
   input  wire [8:0]        csr_data
);

   logic [4:0] limit_ff;
   logic [8:0] rate_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 5'd16;
         rate_ff <= 9'd128;
      end else if (csr_write) begin
         unique case (csr_index)
            stt_pkg::CSR_ENTRY_LIMIT: limit_ff <= csr_data[4:0];
            stt_pkg::CSR_MIN_RATE:    rate_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic             f_valid, f_stall, q_valid, q_stall;
   stt_pkg::cmd_type f_data, q_data;

   stt_front #(.KEY_BITS(KEY_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd_data(f_data));

   stt_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data));

   stt_engine #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_stall(q_stall), .cmd_data(q_data),
      .entry_limit(limit_ff), .min_rate(rate_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

`ifndef SYNTH
   // Only lookups may report a hit, with nonzero count
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.entry_count != 5'd0)
      else $error("hit with empty table");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {27'd0, rsp_data.entry_count} <= 32'(CAPACITY))
      else $error("entry count above capacity");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.found_steps == 16'd0)
      else $error("miss carries steps");
`endif

endmodule
`default_nettype wire

### sv/stt_front.sv
// Front end: accepts requests, masks the key and decodes the function.
// Depends on stt_pkg.
`default_nettype none
module stt_front #(
   parameter int KEY_BITS = 64
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  stt_pkg::req_type req_data,
   output logic             cmd_valid,
   input  wire              cmd_stall,
   output stt_pkg::cmd_type cmd_data
);

   logic             valid_ff, valid_in;
   stt_pkg::cmd_type data_ff, data_in;
   logic [63:0]      mask;

   assign mask = {64{1'b1}} >> (64 - KEY_BITS);
   assign req_stall = valid_ff && cmd_stall;

   // Decode into command
   always_comb begin
      data_in = data_ff;
      valid_in = valid_ff;
      if (valid_ff && !cmd_stall) begin
         valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         valid_in = 1'b1;
         data_in.is_record = req_data.func == stt_pkg::FUNC_RECORD;
         data_in.is_lookup = req_data.func == stt_pkg::FUNC_LOOKUP;
         data_in.is_consol = req_data.func == stt_pkg::FUNC_CONSOLIDATE;
         data_in.key = req_data.key_tag & mask;
         data_in.succeeded = req_data.succeeded;
         data_in.steps = req_data.steps_handle;
         data_in.q_ms = {req_data.duration_ms, 8'd0};
         data_in.now = req_data.now_seconds;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd_data = data_ff;

endmodule
`default_nettype wire

### sv/stt_queue.sv
// Two-entry request queue between front end and table engine.
// Depends on stt_pkg.
`default_nettype none
module stt_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_stall,
   input  stt_pkg::cmd_type in_data,
   output logic             out_valid,
   input  wire              out_stall,
   output stt_pkg::cmd_type out_data
);

   stt_pkg::cmd_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall = cnt_ff == 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end

endmodule
`default_nettype wire

### sv/stt_engine.sv
// Table engine: scans the slots one per cycle, then applies a record update, evaluates a lookup or consolidates.
// Depends on stt_pkg.
`default_nettype none
module stt_engine #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 64
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              cmd_valid,
   output logic             cmd_stall,
   input  stt_pkg::cmd_type cmd_data,
   input  wire [4:0]        entry_limit,
   input  wire [8:0]        min_rate,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output stt_pkg::rsp_type rsp_data
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_EVAL  = 6'b000100,
      ST_APPLY = 6'b001000,
      ST_CONS  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [CAPACITY-1:0] valid_ff;
   logic [KEY_BITS-1:0] key_ff   [CAPACITY];
   logic [15:0]         steps_ff [CAPACITY];
   logic [31:0]         succ_ff  [CAPACITY];
   logic [31:0]         fail_ff  [CAPACITY];
   logic [31:0]         avg_ff   [CAPACITY];
   logic [33:0]         stamp_ff [CAPACITY];
   logic [31:0]         order_ff [CAPACITY];
   logic [31:0]         next_order_ff;

   stt_pkg::cmd_type cmd_ff;
   logic [IW-1:0] idx_ff;
   logic          found_ff, vic_ok_ff, free_ok_ff;
   logic [IW-1:0] hit_idx_ff, vic_idx_ff, free_idx_ff;
   logic [31:0]   vic_succ_ff, vic_order_ff;
   logic [CW-1:0] count_ff;
   stt_pkg::rsp_type out_ff;
   logic          last;
   logic [33:0]   age_ff;

   assign last = idx_ff == IW'(CAPACITY - 1);
   assign cmd_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_data = out_ff;

   // Current slot's scan terms
   logic cur_match, cur_better;
   assign cur_match = valid_ff[idx_ff] && key_ff[idx_ff] == cmd_ff.key[KEY_BITS-1:0];
   assign cur_better = valid_ff[idx_ff] && (!vic_ok_ff || succ_ff[idx_ff] < vic_succ_ff
      || (succ_ff[idx_ff] == vic_succ_ff && order_ff[idx_ff] < vic_order_ff));

   // Limit clamp
   logic [CW-1:0] lim;
   always_comb begin
      if (entry_limit == 5'd0) lim = CW'(1);
      else if ({27'd0, entry_limit} > 32'(CAPACITY)) lim = CW'(CAPACITY);
      else lim = CW'(entry_limit);
   end

   // Lookup rate test on the matched slot
   logic [32:0] tot;
   logic [40:0] lhs;
   logic [41:0] rhs;
   assign tot = {1'b0, succ_ff[hit_idx_ff]} + {1'b0, fail_ff[hit_idx_ff]};
   assign lhs = {succ_ff[hit_idx_ff], 8'd0};

   // Consolidate terms for current slot
   logic [33:0] age_now;
   logic [32:0] c_tot;
   assign age_now = (cmd_ff.now > stamp_ff[idx_ff]) ? cmd_ff.now - stamp_ff[idx_ff] : 34'd0;
   assign c_tot = {1'b0, succ_ff[idx_ff]} + {1'b0, fail_ff[idx_ff]};

   // Day thresholds as age compares: days > N is age >= (N+1) days of seconds
   logic stale, decay;
   assign stale = {1'b0, age_ff} >=
      35'(stt_pkg::SECONDS_PER_DAY) * 35'(stt_pkg::STALE_DAYS + 1);
   assign decay = {1'b0, age_ff} >=
      35'(stt_pkg::SECONDS_PER_DAY) * 35'(stt_pkg::DECAY_DAYS + 1);

   logic [IW-1:0] slot;
   logic          ins;
   assign ins = !found_ff;
   assign slot = found_ff ? hit_idx_ff
               : ((CW'(count_ff) >= lim && vic_ok_ff) ? (free_ok_ff && free_idx_ff < vic_idx_ff
                  ? free_idx_ff : vic_idx_ff) : free_idx_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (cmd_valid) state_in = ST_SCAN;
         ST_SCAN:  if (last) state_in = cmd_ff.is_record ? ST_APPLY : ST_EVAL;
         ST_EVAL:  state_in = cmd_ff.is_consol ? ST_CONS : ST_OUT;
         ST_APPLY: state_in = ST_OUT;
         ST_CONS:  state_in = last ? ST_OUT : ST_EVAL;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign rhs = 42'(min_rate) * 42'(tot);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         next_order_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               cmd_ff <= cmd_data;
               idx_ff <= '0;
               found_ff <= 1'b0;
               vic_ok_ff <= 1'b0;
               free_ok_ff <= 1'b0;
               count_ff <= '0;
               out_ff <= '0;
            end
            ST_SCAN: begin
               // One slot per cycle: match, victim, first free, count
               if (cur_match && !found_ff) begin
                  found_ff <= 1'b1;
                  hit_idx_ff <= idx_ff;
               end
               if (cur_better) begin
                  vic_ok_ff <= 1'b1;
                  vic_idx_ff <= idx_ff;
                  vic_succ_ff <= succ_ff[idx_ff];
                  vic_order_ff <= order_ff[idx_ff];
               end
               if (!valid_ff[idx_ff] && !free_ok_ff) begin
                  free_ok_ff <= 1'b1;
                  free_idx_ff <= idx_ff;
               end
               if (valid_ff[idx_ff]) count_ff <= count_ff + CW'(1);
               idx_ff <= last ? '0 : idx_ff + IW'(1);
            end
            ST_EVAL: begin
               if (cmd_ff.is_lookup) begin
                  if (found_ff && succ_ff[hit_idx_ff] != 32'd0 && {1'b0, lhs} >= rhs) begin
                     out_ff.hit <= 1'b1;
                     out_ff.found_steps <= steps_ff[hit_idx_ff];
                     out_ff.found_avg <= avg_ff[hit_idx_ff];
                  end
                  out_ff.entry_count <= 5'(count_ff);
               end else if (cmd_ff.is_consol) begin
                  age_ff <= age_now;
               end else begin
                  out_ff.entry_count <= 5'(count_ff);
               end
            end
            ST_CONS: begin
               // Prune, decay and drop one slot
               if (valid_ff[idx_ff]) begin
                  if (succ_ff[idx_ff] == 32'd0 && fail_ff[idx_ff] > stt_pkg::FAIL_PRUNE) begin
                     valid_ff[idx_ff] <= 1'b0;
                  end else if (stale && {succ_ff[idx_ff], 1'b0} < c_tot) begin
                     valid_ff[idx_ff] <= 1'b0;
                  end else begin
                     if (decay) succ_ff[idx_ff] <= succ_ff[idx_ff] >> 1;
                     if ((decay ? succ_ff[idx_ff] >> 1 : succ_ff[idx_ff]) == 32'd0)
                        valid_ff[idx_ff] <= 1'b0;
                     else
                        out_ff.entry_count <= out_ff.entry_count + 5'd1;
                  end
               end
               idx_ff <= last ? '0 : idx_ff + IW'(1);
            end
            ST_APPLY: begin
               out_ff.entry_count <= 5'(count_ff) +
                  ((ins && !(count_ff >= lim && vic_ok_ff)) ? 5'd1 : 5'd0);
               if (ins) begin
                  // Victim slot reused by the new key is simply overwritten
                  if (count_ff >= lim && vic_ok_ff && vic_idx_ff != slot)
                     valid_ff[vic_idx_ff] <= 1'b0;
                  valid_ff[slot] <= 1'b1;
                  key_ff[slot] <= cmd_ff.key[KEY_BITS-1:0];
                  order_ff[slot] <= next_order_ff;
                  next_order_ff <= next_order_ff + 32'd1;
               end
               if (cmd_ff.succeeded) begin
                  steps_ff[slot] <= cmd_ff.steps;
                  succ_ff[slot] <= ins ? 32'd1 : (succ_ff[slot] != stt_pkg::SAT32 ?
                     succ_ff[slot] + 32'd1 : succ_ff[slot]);
                  avg_ff[slot] <= (ins || avg_ff[slot] == 32'd0) ? cmd_ff.q_ms :
                     32'(({1'b0, avg_ff[slot]} + {1'b0, cmd_ff.q_ms}) >> 1);
                  if (ins) fail_ff[slot] <= 32'd0;
               end else begin
                  if (ins) begin
                     steps_ff[slot] <= 16'd0;
                     succ_ff[slot] <= 32'd0;
                     avg_ff[slot] <= 32'd0;
                     fail_ff[slot] <= 32'd1;
                  end else if (fail_ff[slot] != stt_pkg::SAT32) begin
                     fail_ff[slot] <= fail_ff[slot] + 32'd1;
                  end
               end
               stamp_ff[slot] <= cmd_ff.now;
            end
            ST_OUT: ;
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

### tb/success_trace_table_check.sv
// Checker for the success trace table: watches both channels and the register
// port, keeps its own copy of the table and compares every response.
// Depends on stt_pkg.
`default_nettype none
module success_trace_table_check (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   input  wire              req_stall,
   input  stt_pkg::req_type req_data,
   input  wire              rsp_valid,
   input  wire              rsp_stall,
   input  stt_pkg::rsp_type rsp_data,
   input  wire              csr_write,
   input  wire [0:0]        csr_index,
   input  wire [8:0]        csr_data,
   output int               mismatch_total,
   output int               pending_count,
   output int               hit_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import stt_pkg::*;

   localparam int SLOTS = 16;

   logic        tv_valid [SLOTS];
   logic [63:0] tv_key   [SLOTS];
   logic [15:0] tv_steps [SLOTS];
   logic [31:0] tv_succ  [SLOTS];
   logic [31:0] tv_fail  [SLOTS];
   logic [31:0] tv_avg   [SLOTS];
   logic [33:0] tv_stamp [SLOTS];
   logic [31:0] tv_order [SLOTS];
   logic [31:0] order_next;
   logic [4:0]  limit_reg;
   logic [8:0]  rate_reg;
   rsp_type     expected_rsp [$];

   function automatic int live_entries();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (tv_valid[i]) n++;
      return n;
   endfunction

   function automatic int slot_of(logic [63:0] key);
      for (int i = 0; i < SLOTS; i++) if (tv_valid[i] && tv_key[i] == key) return i;
      return -1;
   endfunction

   function automatic void record_outcome(req_type r);
      int s, v, lim;
      logic [31:0] q;
      s = slot_of(r.key_tag);
      if (s < 0) begin
         lim = (limit_reg == 0) ? 1 : int'(limit_reg);
         if (lim > SLOTS) lim = SLOTS;
         if (live_entries() >= lim) begin
            // evict fewest successes, oldest insertion on ties
            v = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (!tv_valid[i]) continue;
               if (v < 0 || tv_succ[i] < tv_succ[v] ||
                   (tv_succ[i] == tv_succ[v] && tv_order[i] < tv_order[v])) v = i;
            end
            if (v >= 0) tv_valid[v] = 1'b0;
         end
         s = -1;
         for (int i = 0; i < SLOTS; i++) if (s < 0 && !tv_valid[i]) s = i;
         tv_valid[s] = 1'b1;
         tv_key[s] = r.key_tag;
         tv_steps[s] = '0;
         tv_succ[s] = '0;
         tv_fail[s] = '0;
         tv_avg[s] = '0;
         tv_order[s] = order_next;
         order_next = order_next + 1;
      end
      if (r.succeeded) begin
         q = {r.duration_ms, 8'd0};
         tv_steps[s] = r.steps_handle;
         if (tv_succ[s] != SAT32) tv_succ[s]++;
         if (tv_avg[s] == 0) tv_avg[s] = q;
         else tv_avg[s] = 32'(({1'b0, tv_avg[s]} + {1'b0, q}) >> 1);
      end else if (tv_fail[s] != SAT32) begin
         tv_fail[s]++;
      end
      tv_stamp[s] = r.now_seconds;
   endfunction

   function automatic void consolidate_table(logic [33:0] now);
      logic [33:0] age;
      logic [33:0] days;
      logic [32:0] total;
      for (int i = 0; i < SLOTS; i++) begin
         if (!tv_valid[i]) continue;
         age = (now > tv_stamp[i]) ? now - tv_stamp[i] : '0;
         days = age / SECONDS_PER_DAY;
         total = {1'b0, tv_succ[i]} + {1'b0, tv_fail[i]};
         if (tv_succ[i] == 0 && tv_fail[i] > FAIL_PRUNE) begin
            tv_valid[i] = 1'b0;
         end else if (days > STALE_DAYS && {tv_succ[i], 1'b0} < total) begin
            tv_valid[i] = 1'b0;
         end else begin
            if (days > DECAY_DAYS) tv_succ[i] = tv_succ[i] >> 1;
            if (tv_succ[i] == 0) tv_valid[i] = 1'b0;
         end
      end
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type o;
      int s;
      logic [41:0] lhs, rhs;
      o = '0;
      if (r.func == FUNC_RECORD) begin
         record_outcome(r);
      end else if (r.func == FUNC_LOOKUP) begin
         s = slot_of(r.key_tag);
         if (s >= 0) begin
            lhs = {2'b0, tv_succ[s], 8'd0};
            rhs = 42'(rate_reg) * 42'({1'b0, tv_succ[s]} + {1'b0, tv_fail[s]});
            if (tv_succ[s] != 0 && lhs >= rhs) begin
               o.hit = 1'b1;
               o.found_steps = tv_steps[s];
               o.found_avg = tv_avg[s];
            end
         end
      end else if (r.func == FUNC_CONSOLIDATE) begin
         consolidate_table(r.now_seconds);
      end
      o.entry_count = 5'(live_entries());
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) tv_valid[i] <= 1'b0;
         order_next <= '0;
         limit_reg <= 5'd16;
         rate_reg <= 9'd128;
         expected_rsp.delete();
         mismatch_total <= 0;
         pending_count <= 0;
         hit_count <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_ENTRY_LIMIT) limit_reg = csr_data[4:0];
            else rate_reg = csr_data;
         end
         if (req_valid && !req_stall)
            expected_rsp.insert(expected_rsp.size(), predict_response(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response with none pending: %p", $time, rsp_data);
               mismatch_total <= mismatch_total + 1;
            end else begin
               e = expected_rsp.pop_front();
               if (e.hit) hit_count <= hit_count + 1;
               if (e !== rsp_data) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  mismatch_total <= mismatch_total + 1;
               end
            end
         end
         pending_count <= expected_rsp.size();
      end
   end
endmodule
`default_nettype wire

### tb/success_trace_table_test.sv
// Top of the success trace table testbench: clock, reset, request and register
// stimulus, response stall, watchdog and verdict.
// Depends on stt_pkg, success_trace_table and success_trace_table_check.
`default_nettype none
module success_trace_table_test;
   timeunit 1ns;
   timeprecision 1ps;
   import stt_pkg::*;

   localparam int WATCHDOG = 20000;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   logic    clock, reset;
   logic    req_valid, req_stall;
   req_type req_data;
   logic    rsp_valid, rsp_stall;
   rsp_type rsp_data;
   logic    csr_write;
   logic [0:0] csr_index;
   logic [8:0] csr_data;
   int      mismatch_total, pending_count, hit_count;
   int      idle_cycles, sent_count;
   bit      quiet_phase, hold_rsp;
   logic [63:0] key_pool [8];
   logic [33:0] clock_now;

   success_trace_table dut (.*);
   success_trace_table_check checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("success_trace_table verification failed");
         $finish;
      end
   end

   // response stall: random bursts, one long hold, none at the end
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
            wait (!hold_rsp);
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // write enable is dropped by the caller after the last write
   task automatic write_reg(logic [0:0] idx, logic [8:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
   endtask

   task automatic drain_table();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // one request, held until accepted, sometimes with a random gap before it
   task automatic send_request(req_type r);
      int gap;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   function automatic req_type random_request(bit noise);
      req_type r;
      int pick;
      r.key_tag = noise ? {$urandom, $urandom} : key_pool[$urandom_range(0, 7)];
      pick = $urandom_range(0, 19);
      r.func = pick < 12 ? FUNC_RECORD : pick < 18 ? FUNC_LOOKUP :
               pick < 19 ? FUNC_CONSOLIDATE : FUNC_SPARE;
      r.succeeded = $urandom_range(0, 3) != 0;
      r.steps_handle = 16'($urandom);
      r.duration_ms = $urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'($urandom);
      r.now_seconds = clock_now;
      return r;
   endfunction

   task automatic random_phase(int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         // time steps mostly small, sometimes weeks forward or a little backward
         case ($urandom_range(0, 9))
            0: clock_now = clock_now + 34'($urandom_range(15, 40)) * 34'd86400;
            1: clock_now = clock_now - 34'($urandom_range(0, 5000));
            default: clock_now = clock_now + 34'($urandom_range(0, 20000));
         endcase
         r = random_request($urandom_range(0, 9) == 0);
         send_request(r);
      end
   endtask

   initial begin
      req_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = CSR_ENTRY_LIMIT;
      csr_data = '0;
      quiet_phase = 1'b0;
      hold_rsp = 1'b0;
      sent_count = 0;
      clock_now = 34'd1000;
      for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '1;
      key_pool[1] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every function, unused code, backward clock
      r = '0;
      r.func = FUNC_LOOKUP; send_request(r);
      r.func = FUNC_RECORD; r.key_tag = '1; r.succeeded = 1'b1;
      r.steps_handle = '1; r.duration_ms = '1; r.now_seconds = '1; send_request(r);
      r.duration_ms = 24'd1; send_request(r);
      r.succeeded = 1'b0; send_request(r);
      r.func = FUNC_LOOKUP; send_request(r);
      r.func = FUNC_RECORD; r.key_tag = '0; r.now_seconds = '0; send_request(r);
      send_request(r); send_request(r);
      r.func = FUNC_SPARE; send_request(r);
      r.func = FUNC_CONSOLIDATE; r.now_seconds = 34'd100; send_request(r);
      r.func = FUNC_RECORD; r.key_tag = 64'h5; r.succeeded = 1'b1;
      r.duration_ms = 24'd0; send_request(r);
      r.func = FUNC_CONSOLIDATE; r.now_seconds = 34'd100 + 34'd86400 * 15; send_request(r);
      r.func = FUNC_RECORD; r.key_tag = 64'h6; r.now_seconds = 34'd0; send_request(r);
      r.succeeded = 1'b0; send_request(r); send_request(r);
      r.func = FUNC_CONSOLIDATE; r.now_seconds = 34'd86400 * 40; send_request(r);
      r.func = FUNC_LOOKUP; r.key_tag = '1; send_request(r);
      drain_table();

      // register settings, extremes included, each with a random phase
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin write_reg(CSR_ENTRY_LIMIT, 9'd0); write_reg(CSR_MIN_RATE, 9'd0); end
            1: begin write_reg(CSR_ENTRY_LIMIT, 9'd31); write_reg(CSR_MIN_RATE, 9'd256); end
            2: begin write_reg(CSR_ENTRY_LIMIT, 9'd3); write_reg(CSR_MIN_RATE, 9'd511); end
            3: begin write_reg(CSR_ENTRY_LIMIT, 9'd16); write_reg(CSR_MIN_RATE, 9'd128); end
            4: begin write_reg(CSR_ENTRY_LIMIT, 9'd1); write_reg(CSR_MIN_RATE, 9'd200); end
            default: begin
               write_reg(CSR_ENTRY_LIMIT, 9'($urandom_range(0, 31)));
               write_reg(CSR_MIN_RATE, 9'($urandom));
            end
         endcase
         csr_write <= 1'b0;
         if (ph == 3) begin
            // long receiver hold while requests keep coming
            hold_rsp = 1'b1;
            random_phase(40);
            hold_rsp = 1'b0;
         end
         // fresh keys now and then so eviction sees new traffic
         for (int i = 2; i < 8; i++) if ($urandom_range(0, 1)) key_pool[i] = {$urandom, $urandom};
         if (ph == 6) quiet_phase = 1'b1;
         random_phase(ph == 6 ? 160 : 200);
         drain_table();
      end

      $display("Sent %0d requests over seven register settings; %0d lookups hit.",
               sent_count, hit_count);
      if (mismatch_total == 0) $display("success_trace_table verification clean");
      else $display("success_trace_table verification failed");
      $finish;
   end
endmodule
`default_nettype wire

### success_trace_table.f
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/stt_engine.sv
sv/success_trace_table.sv
tb/success_trace_table_check.sv
tb/success_trace_table_test.sv
